// ===== rtl/wpm_pkg.sv =====
package wpm_pkg;

  // Pattern capacity and the widths that follow from it.
  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int unsigned SET_W       = MAX_PATTERN + 1;

  // Bytes with a special meaning in the pattern.
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] BAR_BYTE  = 8'h7C;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  // Input beat.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] byte_value;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] byte_value;
    logic       is_star;
    logic       is_bar;
  } op_t;

endpackage

// ===== rtl/wildcard_pattern_matcher.sv =====
// Whole-string wildcard matcher. Send a clear, then the pattern one byte
// per beat ('*' matches any run of bytes, a '|' after the first byte cuts
// off the rest of the pattern), then the text bytes, then an end-of-text
// beat, which yields one result beat with the match flag and a flag that
// pattern bytes were dropped because more than 32 arrived. The block accepts
// one beat per clock, sustained while its queue has room, and the text step is
// one pass of the active-position set through a 33-bit carry chain that
// performs the star closure. An end-of-text beat waits only while the previous
// result still sits in the output register and the output is stalled; a two-beat
// queue between the input side and the matching logic absorbs that wait, and a
// result is valid on the output from the clock edge at which the back takes its
// end-of-text beat from the queue, which an earlier stalled result delays.
module wildcard_pattern_matcher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wpm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wpm_pkg::out_t out_data_o
);

  logic         op_valid;
  wpm_pkg::op_t op;
  logic         op_pop;

  // Accept and classify beats.
  wpm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  // Hold the pattern, step the active set and deliver results.
  wpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/wpm_front.sv =====
module wpm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wpm_pkg::in_t   in_data_i,
  output logic           op_valid_o,
  output wpm_pkg::op_t   op_o,
  input  logic           op_pop_i
);

  localparam int unsigned Depth = 2;

  logic [1:0]   count_q, count_d;
  logic         wr_ptr_q, rd_ptr_q;
  wpm_pkg::op_t mem_q [Depth];
  wpm_pkg::op_t op_in;
  logic         full;
  logic         push;

  // Classify the incoming beat so the back only looks at flags.
  always_comb begin
    op_in.cmd        = in_data_i.cmd;
    op_in.byte_value = in_data_i.byte_value;
    op_in.is_star    = (in_data_i.byte_value == wpm_pkg::STAR_BYTE);
    op_in.is_bar     = (in_data_i.byte_value == wpm_pkg::BAR_BYTE);
  end

  // The stall comes straight from the fill level, so it never waits on valid.
  assign full       = (count_q == 2'd2);
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  // Fill level of the queue.
  always_comb begin
    unique case ({push, op_pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (op_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= op_in;
    end
  end

  assign op_valid_o = (count_q != 2'd0);
  assign op_o       = mem_q[rd_ptr_q];

endmodule

// ===== rtl/wpm_back.sv =====
module wpm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  wpm_pkg::op_t   op_i,
  output logic           op_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wpm_pkg::out_t  out_data_o
);

  localparam int unsigned MaxPat = wpm_pkg::MAX_PATTERN;
  localparam int unsigned LenW   = wpm_pkg::LEN_W;
  localparam int unsigned SetW   = wpm_pkg::SET_W;

  logic [7:0]      pat_q [MaxPat];
  logic [MaxPat-1:0] star_q;
  logic [LenW-1:0] len_q;
  logic            cut_q;
  logic            ovf_q;
  logic [SetW-1:0] active_q;
  logic [SetW-1:0] lead_q;
  logic            out_valid_q;
  wpm_pkg::out_t   out_data_q;

  logic              go;
  logic              is_end;
  logic              is_append;
  logic              full;
  logic              bar_cut;
  logic              keep;
  logic [MaxPat-1:0] kept;
  logic [SetW-1:0]   lead_next;
  logic [SetW-1:0]   next_set;
  logic [SetW-1:0]   star_m;
  logic [SetW-1:0]   launch;
  logic [SetW:0]     sum;
  logic [SetW:0]     carry;
  logic [SetW-1:0]   closed;

  // An end-of-text beat needs room in the output register; all else goes at once.
  assign is_end    = (op_i.cmd == wpm_pkg::CMD_END);
  assign is_append = (op_i.cmd == wpm_pkg::CMD_APPEND);
  assign go        = op_valid_i && (!is_end || !out_valid_q || !out_stall_i);
  assign op_pop_o  = go;

  // Decide what an append does with its byte.
  assign full    = (len_q == LenW'(MaxPat));
  assign bar_cut = (len_q != '0) && op_i.is_bar;
  assign keep    = !cut_q && !bar_cut && !full;

  // Positions that hold a pattern byte.
  always_comb begin
    for (int i = 0; i < MaxPat; i++) begin
      kept[i] = (LenW'(i) < len_q);
    end
  end

  // The closed start set grows while the pattern so far is all stars.
  always_comb begin
    lead_next = lead_q;
    for (int i = 0; i < MaxPat; i++) begin
      if ((len_q == LenW'(i)) && lead_q[i] && op_i.is_star) begin
        lead_next[i+1] = 1'b1;
      end
    end
  end

  // Step the active set over one text byte. The set is kept closed, so
  // the step works on it directly.
  always_comb begin
    next_set = '0;
    for (int i = 0; i < MaxPat; i++) begin
      if (kept[i] && active_q[i]) begin
        if (star_q[i]) begin
          next_set[i] = 1'b1;
        end else if (pat_q[i] == op_i.byte_value) begin
          next_set[i+1] = 1'b1;
        end
      end
    end
  end

  // Star closure as a carry chain: an active star launches a carry that
  // runs through the following stars and lands on the first non-star.
  assign star_m = {1'b0, star_q & kept};
  assign launch = next_set & star_m;
  assign sum    = {1'b0, star_m} + {1'b0, launch};
  assign carry  = sum ^ {1'b0, star_m} ^ {1'b0, launch};
  assign closed = next_set | carry[SetW-1:0];

  // Control state and the active set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      cut_q    <= 1'b0;
      ovf_q    <= 1'b0;
      lead_q   <= SetW'(1);
      active_q <= SetW'(1);
    end else if (go) begin
      unique case (op_i.cmd)
        wpm_pkg::CMD_CLEAR: begin
          len_q    <= '0;
          cut_q    <= 1'b0;
          ovf_q    <= 1'b0;
          lead_q   <= SetW'(1);
          active_q <= SetW'(1);
        end
        wpm_pkg::CMD_APPEND: begin
          priority if (cut_q) begin
            active_q <= lead_q;
          end else if (bar_cut) begin
            cut_q    <= 1'b1;
            active_q <= lead_q;
          end else if (full) begin
            ovf_q    <= 1'b1;
            active_q <= lead_q;
          end else begin
            len_q    <= len_q + LenW'(1);
            lead_q   <= lead_next;
            active_q <= lead_next;
          end
        end
        wpm_pkg::CMD_TEXT: begin
          active_q <= closed;
        end
        wpm_pkg::CMD_END: begin
          active_q <= lead_q;
        end
        default: begin
          active_q <= active_q;
        end
      endcase
    end
  end

  // Pattern storage, written at the current length.
  always_ff @(posedge clk_i) begin
    if (go && is_append && keep) begin
      for (int i = 0; i < MaxPat; i++) begin
        if (len_q == LenW'(i)) begin
          pat_q[i]  <= op_i.byte_value;
          star_q[i] <= op_i.is_star;
        end
      end
    end
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && is_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && is_end) begin
      out_data_q.matched          <= active_q[len_q];
      out_data_q.pattern_overflow <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== dv/tb_wildcard_pattern_matcher.sv =====
`timescale 1ns / 1ps

// Tracks the matcher state for every accepted input beat and holds the result
// beats that the end-of-text beats are due to produce, oldest first.
class match_scoreboard;
  typedef logic [wpm_pkg::SET_W-1:0] set_t;

  logic [7:0]    pattern_bytes [wpm_pkg::MAX_PATTERN];
  int unsigned   pattern_len;
  bit            cut_seen;
  bit            overflow_seen;
  set_t          live_set;
  wpm_pkg::out_t expected_results [$];
  int unsigned   mismatches;

  function new();
    foreach (pattern_bytes[i]) pattern_bytes[i] = 8'h00;
    pattern_len   = 0;
    cut_seen      = 1'b0;
    overflow_seen = 1'b0;
    live_set      = set_t'(1);
    mismatches    = 0;
  endfunction

  // An active position sitting on a star also activates the next position.
  // The loop runs upwards, so a chain of stars is closed in one pass.
  function set_t star_closure(set_t s);
    for (int i = 0; i < wpm_pkg::MAX_PATTERN; i++) begin
      if (i < pattern_len && s[i] && pattern_bytes[i] == wpm_pkg::STAR_BYTE) s[i+1] = 1'b1;
    end
    return s;
  endfunction

  // Moves the set of active positions on by one text byte.
  function set_t consume_text(set_t s, logic [7:0] c);
    set_t nxt;
    nxt = '0;
    s = star_closure(s);
    for (int i = 0; i < wpm_pkg::MAX_PATTERN; i++) begin
      if (i < pattern_len && s[i]) begin
        if (pattern_bytes[i] == wpm_pkg::STAR_BYTE) nxt[i] = 1'b1;
        else if (pattern_bytes[i] == c) nxt[i+1] = 1'b1;
      end
    end
    return star_closure(nxt);
  endfunction

  task report(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Updates the state for one accepted input beat.
  function void note_beat(wpm_pkg::in_t beat);
    set_t          closed;
    wpm_pkg::out_t res;
    case (beat.cmd)
      wpm_pkg::CMD_CLEAR: begin
        pattern_len   = 0;
        cut_seen      = 1'b0;
        overflow_seen = 1'b0;
        live_set      = set_t'(1);
      end
      wpm_pkg::CMD_APPEND: begin
        // Any append, kept or not, restarts the text.
        live_set = set_t'(1);
        if (!cut_seen) begin
          if (pattern_len > 0 && beat.byte_value == wpm_pkg::BAR_BYTE) begin
            cut_seen = 1'b1;
          end else if (pattern_len >= wpm_pkg::MAX_PATTERN) begin
            overflow_seen = 1'b1;
          end else begin
            pattern_bytes[pattern_len] = beat.byte_value;
            pattern_len++;
          end
        end
      end
      wpm_pkg::CMD_TEXT: begin
        live_set = consume_text(live_set, beat.byte_value);
      end
      wpm_pkg::CMD_END: begin
        closed               = star_closure(live_set);
        res.matched          = closed[pattern_len];
        res.pattern_overflow = overflow_seen;
        expected_results.insert(expected_results.size(), res);
        live_set             = set_t'(1);
      end
    endcase
  endfunction

  // Compares one accepted result beat with the oldest expectation.
  task check_result(wpm_pkg::out_t got);
    wpm_pkg::out_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result beat %b with no expectation waiting", got));
    end else begin
      want = expected_results.pop_front();
      if (got.matched !== want.matched)
        report($sformatf("matched is %b, expected %b", got.matched, want.matched));
      if (got.pattern_overflow !== want.pattern_overflow)
        report($sformatf("pattern_overflow is %b, expected %b",
                         got.pattern_overflow, want.pattern_overflow));
    end
  endtask

  function int unsigned pending();
    return expected_results.size();
  endfunction
endclass

module tb_wildcard_pattern_matcher;

  localparam int unsigned TOTAL_BEATS  = 775;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  wpm_pkg::in_t  in_data_i   = '{cmd: wpm_pkg::CMD_CLEAR, byte_value: 8'h00};
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  wpm_pkg::out_t out_data_o;

  match_scoreboard sb = new();

  int unsigned sent_beats = 0;
  int unsigned idle_cycles = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          pressure_done = 1'b0;
  bit          pause_done = 1'b0;

  wildcard_pattern_matcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Both channels are observed at the clock edge, and the watchdog ends the run
  // when neither side has moved a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_beat(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: a random stall before each result, quiet stretches now and then,
  // and one long hold-off on request.
  initial begin
    int w;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      w = rx_quiet ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o && !hold_req) @(posedge clk_i);
    end
  end

  // Offers one input beat after a random gap and returns once it is accepted.
  // Valid stays high on return, so a following beat with no gap is back to back.
  task automatic drive_beat(wpm_pkg::cmd_e cmd, logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{cmd: cmd, byte_value: b};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_beats++;
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Text bytes lean on a small alphabet so that literals match often.
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 8'h61 + 8'($urandom_range(0, 2));
    if (r == 14) return wpm_pkg::STAR_BYTE;
    if (r == 15) return wpm_pkg::BAR_BYTE;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pattern_byte(bit long_pattern);
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 19);
    if (r < 10) b = 8'h61 + 8'($urandom_range(0, 2));
    else if (r < 15) b = wpm_pkg::STAR_BYTE;
    else if (r == 15) b = wpm_pkg::BAR_BYTE;
    else b = 8'($urandom);
    // Long patterns are meant to overflow, so a cut is made rare there.
    if (long_pattern && b == wpm_pkg::BAR_BYTE && $urandom_range(0, 3) != 0) b = 8'h61;
    return b;
  endfunction

  // Edge cases: empty pattern, a bar as the first byte, the cut, the dead set,
  // a lone star, the extreme byte values and an append in the middle of a text.
  task automatic run_directed();
    tx_quiet = 1'b0;
    drive_beat(wpm_pkg::CMD_END, 8'hFF);
    drive_beat(wpm_pkg::CMD_TEXT, 8'h00);
    drive_beat(wpm_pkg::CMD_END, 8'h00);
    drive_beat(wpm_pkg::CMD_APPEND, wpm_pkg::BAR_BYTE);
    drive_beat(wpm_pkg::CMD_TEXT, wpm_pkg::BAR_BYTE);
    drive_beat(wpm_pkg::CMD_END, 8'h00);
    drive_beat(wpm_pkg::CMD_APPEND, wpm_pkg::STAR_BYTE);
    drive_beat(wpm_pkg::CMD_APPEND, wpm_pkg::BAR_BYTE);
    drive_beat(wpm_pkg::CMD_APPEND, 8'hFF);
    drive_beat(wpm_pkg::CMD_TEXT, wpm_pkg::BAR_BYTE);
    drive_beat(wpm_pkg::CMD_TEXT, 8'hFF);
    drive_beat(wpm_pkg::CMD_END, 8'hFF);
    drive_beat(wpm_pkg::CMD_TEXT, 8'h61);
    drive_beat(wpm_pkg::CMD_TEXT, 8'h62);
    drive_beat(wpm_pkg::CMD_END, 8'h00);
    drive_beat(wpm_pkg::CMD_CLEAR, 8'hFF);
    drive_beat(wpm_pkg::CMD_APPEND, wpm_pkg::STAR_BYTE);
    drive_beat(wpm_pkg::CMD_END, 8'h00);
    drive_beat(wpm_pkg::CMD_APPEND, 8'hFF);
    drive_beat(wpm_pkg::CMD_TEXT, 8'h00);
    drive_beat(wpm_pkg::CMD_TEXT, 8'hFF);
    drive_beat(wpm_pkg::CMD_END, 8'h00);
    drive_beat(wpm_pkg::CMD_TEXT, 8'h01);
    drive_beat(wpm_pkg::CMD_APPEND, wpm_pkg::STAR_BYTE);
    drive_beat(wpm_pkg::CMD_TEXT, 8'hFF);
    drive_beat(wpm_pkg::CMD_END, 8'h00);
  endtask

  // One session: mostly a clear, a pattern and a few texts built to follow the
  // pattern or drawn at random; sometimes just noise.
  task automatic run_session();
    logic [7:0] kept [$];
    int         plen;
    bit         long_pattern;
    bit         cut;
    logic [7:0] b;
    tx_quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        drive_beat(wpm_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    if ($urandom_range(0, 9) != 0) drive_beat(wpm_pkg::CMD_CLEAR, 8'($urandom));
    long_pattern = ($urandom_range(0, 11) == 0);
    plen = long_pattern ? $urandom_range(30, 36) : $urandom_range(0, 6);
    cut = 1'b0;
    repeat (plen) begin
      b = pattern_byte(long_pattern);
      if (!cut && kept.size() > 0 && b == wpm_pkg::BAR_BYTE) cut = 1'b1;
      else if (!cut && kept.size() < wpm_pkg::MAX_PATTERN) kept.insert(kept.size(), b);
      drive_beat(wpm_pkg::CMD_APPEND, b);
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 1) == 1) begin
        // Text that follows the pattern, with the odd byte spoilt.
        foreach (kept[i]) begin
          if (kept[i] == wpm_pkg::STAR_BYTE)
            repeat ($urandom_range(0, 2)) drive_beat(wpm_pkg::CMD_TEXT, text_byte());
          else
            drive_beat(wpm_pkg::CMD_TEXT,
                       ($urandom_range(0, 7) == 0) ? text_byte() : kept[i]);
        end
      end else begin
        repeat ($urandom_range(0, 6)) drive_beat(wpm_pkg::CMD_TEXT, text_byte());
      end
      drive_beat(wpm_pkg::CMD_END, 8'($urandom));
    end
  endtask

  // The receiver holds off while end-of-text beats arrive back to back, so the
  // block fills up and has to stall its input.
  task automatic run_pressure();
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    drive_beat(wpm_pkg::CMD_CLEAR, 8'h00);
    drive_beat(wpm_pkg::CMD_APPEND, wpm_pkg::STAR_BYTE);
    drive_beat(wpm_pkg::CMD_APPEND, 8'h61);
    repeat (8) begin
      drive_beat(wpm_pkg::CMD_TEXT, text_byte());
      drive_beat(wpm_pkg::CMD_END, 8'h00);
      drive_beat(wpm_pkg::CMD_END, 8'hFF);
    end
    tx_quiet = 1'b0;
    wait_drained();
  endtask

  // Main sequence.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_drained();
    while (sent_beats < TOTAL_BEATS) begin
      if (!pressure_done && sent_beats > 350) begin
        pressure_done = 1'b1;
        run_pressure();
      end
      if (!pause_done && sent_beats > 550) begin
        pause_done = 1'b1;
        wait_drained();
      end
      run_session();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wpm_pkg.sv
rtl/wpm_front.sv
rtl/wpm_back.sv
rtl/wildcard_pattern_matcher.sv
dv/tb_wildcard_pattern_matcher.sv
